@@ design/swvm_pkg.sv @@
// Package with sizes, command codes and shared types of the wavetable voice mixer.
`timescale 1ns / 1ps
`default_nettype none
package swvm_pkg;
    localparam int NUM_TRACKS = 16;
    localparam int COMMANDS_PER_TRACK = 256;
    localparam int TABLE_SIZE = 8192;
    localparam int TICK_DIVIDE = 16;
    localparam int TRK_W = $clog2(NUM_TRACKS);
    localparam int ENT_W = $clog2(COMMANDS_PER_TRACK);
    localparam int TAB_W = $clog2(TABLE_SIZE);
    localparam int LEN_W = $clog2(COMMANDS_PER_TRACK + 1);
    localparam int DIV_W = $clog2(TICK_DIVIDE + 1);
    localparam int CNT_W = $clog2(NUM_TRACKS + 1);

    typedef enum logic [2:0] {
        t_CMD_SINE = 3'd0,
        t_CMD_ENTRY = 3'd1,
        t_CMD_LENGTH = 3'd2,
        t_CMD_TICK = 3'd3,
        t_CMD_SAMPLE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_TICK_RD,
        t_ST_TICK_WR,
        t_ST_SMP_RD,
        t_ST_SMP_WR,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic        note_on;
        logic [12:0] step;
        logic [15:0] delay;
    } t_entry;
endpackage
`default_nettype wire

@@ design/swvm_cmd_ram.sv @@
// Command store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module swvm_cmd_ram (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [swvm_pkg::TRK_W+swvm_pkg::ENT_W-1:0]    i_waddr,
    input  wire swvm_pkg::t_entry                              i_wdata,
    input  wire logic [swvm_pkg::TRK_W+swvm_pkg::ENT_W-1:0]    i_raddr,
    output swvm_pkg::t_entry                                   o_rdata
);
    swvm_pkg::t_entry r_mem [swvm_pkg::NUM_TRACKS*swvm_pkg::COMMANDS_PER_TRACK];
    swvm_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rdata = r_rd;
endmodule
`default_nettype wire

@@ design/sequenced_wavetable_voice_mixer.sv @@
// Top level: wavetable voice mixer with per-track note sequencers.
// Channel | Direction | Signals
// s_axis  | in        | tvalid/tready/tdata (all load, tick and sample fields)
// m_axis  | out       | tvalid/tready/tdata (mix_sample)
// cfg     | in        | i_cfg_we/i_cfg_wdata (active_tracks)
// Load items and ticks that do not step the tracks leave the block idle. Stepping
// ticks and sample items visit each active track in turn, through a read state and
// a write state per track for the registered command and table reads.
// A finished sample waits in the output state only while the previous result is unread.
// Reset is synchronous and clears the per-track registers and the divider.
`timescale 1ns / 1ps
`default_nettype none
module sequenced_wavetable_voice_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[2:0], track[6:3], entry_index[14:7], table_index[27:15],
    // table_value[43:28], is_note_on[44], phase_step[57:45],
    // delay_ticks[73:58], track_length[82:74]
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mix_sample[15:0]
    output logic [15:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata
);
    localparam int TW = swvm_pkg::TRK_W;
    localparam int EW = swvm_pkg::ENT_W;
    localparam int AW = swvm_pkg::TAB_W;
    localparam int LW = swvm_pkg::LEN_W;

    logic [2:0]  f_cmd;
    logic [3:0]  f_track;
    logic [7:0]  f_entry;
    logic [12:0] f_tidx;
    logic [15:0] f_tval;
    logic        f_note;
    logic [12:0] f_step;
    logic [15:0] f_delay;
    logic [8:0]  f_len;
    assign f_cmd   = s_axis_tdata[2:0];
    assign f_track = s_axis_tdata[6:3];
    assign f_entry = s_axis_tdata[14:7];
    assign f_tidx  = s_axis_tdata[27:15];
    assign f_tval  = s_axis_tdata[43:28];
    assign f_note  = s_axis_tdata[44];
    assign f_step  = s_axis_tdata[57:45];
    assign f_delay = s_axis_tdata[73:58];
    assign f_len   = s_axis_tdata[82:74];

    swvm_pkg::t_state r_state, n_state;
    logic [4:0]  r_active;
    logic [swvm_pkg::DIV_W-1:0] r_div;
    logic [TW-1:0] r_t;
    logic [15:0] r_sum;
    logic        r_ovalid;
    logic [15:0] r_out;
    logic [AW-1:0] r_phase [swvm_pkg::NUM_TRACKS];
    logic        r_pv [swvm_pkg::NUM_TRACKS];
    logic [EW-1:0] r_pos [swvm_pkg::NUM_TRACKS];
    logic [15:0] r_wait [swvm_pkg::NUM_TRACKS];
    logic [LW-1:0] r_len [swvm_pkg::NUM_TRACKS];

    logic [15:0] r_sine [swvm_pkg::TABLE_SIZE];
    logic [15:0] r_sine_rd;

    logic        accept;
    logic [swvm_pkg::CNT_W-1:0] ntr;
    logic        last_t;
    logic        out_free;
    logic        cmd_we;
    logic [TW+EW-1:0] cmd_waddr, cmd_raddr;
    swvm_pkg::t_entry cmd_wdata, cmd_rd;

    logic [EW:0] nxt, cur, aft;
    logic        nv_ok;
    logic [EW-1:0] newpos;
    logic        newpv;

    assign s_axis_tready = (r_state == swvm_pkg::t_ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;
    assign out_free = !r_ovalid || m_axis_tready;
    assign ntr = (r_active > 5'(swvm_pkg::NUM_TRACKS)) ?
                 swvm_pkg::CNT_W'(swvm_pkg::NUM_TRACKS) : swvm_pkg::CNT_W'(r_active);
    assign last_t = (swvm_pkg::CNT_W'(r_t) + 1'b1) >= ntr;

    assign cmd_we = accept && (swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_ENTRY) &&
                    ({1'b0, f_track} < 5'(swvm_pkg::NUM_TRACKS)) &&
                    ({1'b0, f_entry} < 9'(swvm_pkg::COMMANDS_PER_TRACK));
    assign cmd_waddr = {f_track[TW-1:0], f_entry[EW-1:0]};
    assign cmd_wdata = '{note_on: f_note, step: f_step, delay: f_delay};

    // Tick needs the entry after the new position; sample needs the current one.
    always_comb begin
        nxt = r_pv[r_t] ? ({1'b0, r_pos[r_t]} + 1'b1) : '0;
        nv_ok = {1'b0, nxt} < {1'b0, r_len[r_t]};
        newpos = nv_ok ? nxt[EW-1:0] : r_pos[r_t];
        newpv = nv_ok || r_pv[r_t];
        cur = {1'b0, newpos};
        aft = cur + 1'b1;
        if (r_state == swvm_pkg::t_ST_TICK_RD) begin
            cmd_raddr = {r_t, aft[EW-1:0]};
        end else begin
            cmd_raddr = {r_t, r_pos[r_t]};
        end
    end

    swvm_cmd_ram u_cmd (
        .i_clk(i_clk), .i_we(cmd_we), .i_waddr(cmd_waddr), .i_wdata(cmd_wdata),
        .i_raddr(cmd_raddr), .o_rdata(cmd_rd)
    );

    always_ff @(posedge i_clk) begin
        if (accept && (swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_SINE) &&
            ({1'b0, f_tidx} < 14'(swvm_pkg::TABLE_SIZE))) begin
            r_sine[f_tidx[AW-1:0]] <= f_tval;
        end
        r_sine_rd <= r_sine[r_phase[r_t]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swvm_pkg::t_ST_IDLE: begin
                if (accept && swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_SAMPLE) begin
                    n_state = (ntr == '0) ? swvm_pkg::t_ST_OUT : swvm_pkg::t_ST_SMP_RD;
                end else if (accept && swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_TICK &&
                             r_div >= swvm_pkg::DIV_W'(swvm_pkg::TICK_DIVIDE) &&
                             ntr != '0) begin
                    n_state = swvm_pkg::t_ST_TICK_RD;
                end
            end
            swvm_pkg::t_ST_TICK_RD: n_state = swvm_pkg::t_ST_TICK_WR;
            swvm_pkg::t_ST_TICK_WR:
                n_state = last_t ? swvm_pkg::t_ST_IDLE : swvm_pkg::t_ST_TICK_RD;
            swvm_pkg::t_ST_SMP_RD: n_state = swvm_pkg::t_ST_SMP_WR;
            swvm_pkg::t_ST_SMP_WR:
                n_state = last_t ? swvm_pkg::t_ST_OUT : swvm_pkg::t_ST_SMP_RD;
            swvm_pkg::t_ST_OUT:
                n_state = out_free ? swvm_pkg::t_ST_IDLE : swvm_pkg::t_ST_OUT;
            default: n_state = swvm_pkg::t_ST_IDLE;
        endcase
    end

    logic [AW:0] psum;
    assign psum = {1'b0, r_phase[r_t]} + {1'b0, cmd_rd.step[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swvm_pkg::t_ST_IDLE;
            r_active <= '0;
            r_div <= '0;
            r_t <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < swvm_pkg::NUM_TRACKS; i++) begin
                r_phase[i] <= '0;
                r_pv[i] <= 1'b0;
                r_pos[i] <= '0;
                r_wait[i] <= '0;
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (accept) begin
                r_t <= '0;
                r_sum <= '0;
                if (swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_TICK) begin
                    r_div <= (r_div >= swvm_pkg::DIV_W'(swvm_pkg::TICK_DIVIDE)) ?
                             swvm_pkg::DIV_W'(1) : r_div + 1'b1;
                end
                if (swvm_pkg::t_cmd'(f_cmd) == swvm_pkg::t_CMD_LENGTH &&
                    {1'b0, f_track} < 5'(swvm_pkg::NUM_TRACKS)) begin
                    r_len[f_track[TW-1:0]] <=
                        (f_len > 9'(swvm_pkg::COMMANDS_PER_TRACK)) ?
                        LW'(swvm_pkg::COMMANDS_PER_TRACK) : LW'(f_len);
                    r_pv[f_track[TW-1:0]] <= 1'b0;
                    r_pos[f_track[TW-1:0]] <= '0;
                    r_wait[f_track[TW-1:0]] <= f_delay;
                end
            end
            if (r_state == swvm_pkg::t_ST_TICK_WR) begin
                if (r_wait[r_t] != '0) begin
                    r_wait[r_t] <= r_wait[r_t] - 1'b1;
                end else begin
                    r_pos[r_t] <= newpos;
                    r_pv[r_t] <= newpv;
                    if (newpv && {1'b0, aft} < {1'b0, r_len[r_t]}) begin
                        r_wait[r_t] <= cmd_rd.delay;
                    end
                end
                r_t <= r_t + 1'b1;
            end
            if (r_state == swvm_pkg::t_ST_SMP_WR) begin
                r_sum <= r_sum + {{4{r_sine_rd[15]}}, r_sine_rd[15:4]};
                if (r_pv[r_t] && cmd_rd.note_on) begin
                    r_phase[r_t] <= psum[AW-1:0];
                end
                r_t <= r_t + 1'b1;
            end
            if (r_state == swvm_pkg::t_ST_OUT && out_free) begin
                r_out <= r_sum;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != swvm_pkg::t_ST_IDLE) |-> !s_axis_tready)
        else $error("item accepted while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == swvm_pkg::t_ST_OUT))
        else $error("result without a finished sample");
    a_track_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swvm_pkg::t_ST_SMP_WR || r_state == swvm_pkg::t_ST_TICK_WR)
        |-> (swvm_pkg::CNT_W'(r_t) < ntr))
        else $error("track index past active count");
endmodule
`default_nettype wire

@@ tb/swvm_mix_checker.sv @@
// Checker that predicts the mixed samples of the voice mixer and compares them with its output.
`timescale 1ns / 1ps
`default_nettype none
module swvm_mix_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [87:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);
    logic [15:0]      wave_mem [swvm_pkg::TABLE_SIZE];
    swvm_pkg::t_entry note_mem [swvm_pkg::NUM_TRACKS][swvm_pkg::COMMANDS_PER_TRACK];
    logic [swvm_pkg::TAB_W-1:0] phase [swvm_pkg::NUM_TRACKS];
    bit               pos_ok [swvm_pkg::NUM_TRACKS];
    int               pos [swvm_pkg::NUM_TRACKS];
    int               track_len [swvm_pkg::NUM_TRACKS];
    logic [15:0]      wait_cnt [swvm_pkg::NUM_TRACKS];
    int               tick_div;
    int               active;
    logic [15:0]      mix_q [$];

    function automatic int voices();
        return (active > swvm_pkg::NUM_TRACKS) ? swvm_pkg::NUM_TRACKS : active;
    endfunction

    function automatic void advance_tracks();
        int nxt;
        for (int t = 0; t < voices(); t++) begin
            if (wait_cnt[t] != 0) begin
                wait_cnt[t] = wait_cnt[t] - 16'd1;
            end else begin
                nxt = pos_ok[t] ? pos[t] + 1 : 0;
                if (nxt < track_len[t]) begin
                    pos[t] = nxt;
                    pos_ok[t] = 1'b1;
                end
                if (pos_ok[t] && (pos[t] + 1 < track_len[t]))
                    wait_cnt[t] = note_mem[t][pos[t] + 1].delay;
            end
        end
    endfunction

    function automatic logic [15:0] mix_voices();
        logic [15:0] sum;
        logic [15:0] raw;
        sum = '0;
        for (int t = 0; t < voices(); t++) begin
            raw = wave_mem[phase[t]];
            sum = sum + {{4{raw[15]}}, raw[15:4]};
            // The phase sum always fits in one wrap, so truncation is exact.
            if (pos_ok[t] && note_mem[t][pos[t]].note_on)
                phase[t] = phase[t] + note_mem[t][pos[t]].step;
        end
        return sum;
    endfunction

    always @(posedge i_clk) begin
        swvm_pkg::t_cmd c;
        logic [3:0]  trk;
        logic [8:0]  ln;
        logic [15:0] want;
        if (!i_rst_n) begin
            for (int t = 0; t < swvm_pkg::NUM_TRACKS; t++) begin
                phase[t] = '0;
                pos_ok[t] = 1'b0;
                pos[t] = 0;
                track_len[t] = 0;
                wait_cnt[t] = '0;
            end
            tick_div = 0;
            active = 0;
            o_errors = 0;
            mix_q.delete();
        end else begin
            if (i_cfg_we)
                active = int'(i_cfg_wdata);
            if (i_in_valid && i_in_ready) begin
                c = swvm_pkg::t_cmd'(i_in_data[2:0]);
                trk = i_in_data[6:3];
                case (c)
                    swvm_pkg::t_CMD_SINE: wave_mem[i_in_data[27:15]] = i_in_data[43:28];
                    swvm_pkg::t_CMD_ENTRY: note_mem[trk][i_in_data[14:7]] =
                        {i_in_data[44], i_in_data[57:45], i_in_data[73:58]};
                    swvm_pkg::t_CMD_LENGTH: begin
                        ln = i_in_data[82:74];
                        track_len[trk] = (int'(ln) > swvm_pkg::COMMANDS_PER_TRACK) ?
                                         swvm_pkg::COMMANDS_PER_TRACK : int'(ln);
                        pos_ok[trk] = 1'b0;
                        pos[trk] = 0;
                        wait_cnt[trk] = i_in_data[73:58];
                    end
                    swvm_pkg::t_CMD_TICK: begin
                        if (tick_div >= swvm_pkg::TICK_DIVIDE) begin
                            advance_tracks();
                            tick_div = 0;
                        end
                        tick_div++;
                    end
                    swvm_pkg::t_CMD_SAMPLE: mix_q.push_back(mix_voices());
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (mix_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("Unexpected sample %h with nothing pending", i_out_data);
                end else begin
                    want = mix_q.pop_front();
                    if (i_out_data !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("Sample mismatch: expected %h, got %h", want, i_out_data);
                    end
                end
            end
        end
        o_pending = mix_q.size();
    end
endmodule
`default_nettype wire

@@ tb/sequenced_wavetable_voice_mixer_tb.sv @@
// Testbench top that drives load, tick and sample items into the voice mixer and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module sequenced_wavetable_voice_mixer_tb;
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    int  send_idle = 27;
    int  recv_idle = 62;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  entry_done [swvm_pkg::NUM_TRACKS][swvm_pkg::COMMANDS_PER_TRACK];

    always #5 i_clk = ~i_clk;

    sequenced_wavetable_voice_mixer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    swvm_mix_checker mix_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0)
            hold_left = 400;
        else if (hold_left > 0)
            hold_left--;
        if (hold_left > 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send(input logic [2:0] c, input logic [3:0] trk, input logic [7:0] ent,
                        input logic [12:0] ti, input logic [15:0] tv, input logic non,
                        input logic [12:0] st, input logic [15:0] dl, input logic [8:0] ln);
        int gap;
        gap = ($urandom_range(99) < send_idle) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, ln, dl, st, non, tv, ti, ent, trk, c};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] c);
        send(c, 4'($urandom), 8'($urandom), 13'($urandom), 16'($urandom), 1'($urandom),
             13'($urandom), 16'($urandom), 9'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_voices(input logic [4:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every entry that a track of the given length can reach is written before the length.
    // Steps are multiples of 64, so phases only reach the table entries loaded below.
    task automatic load_track(input logic [3:0] trk, input logic [8:0] ln,
                              input logic [15:0] first_wait);
        int n;
        logic [12:0] st;
        logic [15:0] dl;
        n = (int'(ln) > swvm_pkg::COMMANDS_PER_TRACK) ? swvm_pkg::COMMANDS_PER_TRACK :
            int'(ln);
        for (int e = 0; e < n; e++) begin
            if (!entry_done[trk][e] || $urandom_range(1)) begin
                st = ($urandom_range(3) == 0) ? {7'($urandom), 6'd0} :
                     {7'($urandom_range(5)), 6'd0};
                dl = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
                send(swvm_pkg::t_CMD_ENTRY, trk, 8'(e), 13'($urandom), 16'($urandom),
                     1'($urandom), st, dl, 9'($urandom));
                entry_done[trk][e] = 1'b1;
            end
        end
        send(swvm_pkg::t_CMD_LENGTH, trk, 8'($urandom), 13'($urandom), 16'($urandom),
             1'($urandom), 13'($urandom), first_wait, ln);
    endtask

    task automatic random_items(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_op(swvm_pkg::t_CMD_SINE);
            else if (pick < 18)
                load_track(4'($urandom), ($urandom_range(49) == 0) ?
                           9'($urandom_range(24, 7)) : 9'($urandom_range(6)),
                           16'($urandom_range(2)));
            else if (pick < 55)
                send_op(swvm_pkg::t_CMD_TICK);
            else if (pick < 97)
                send_op(swvm_pkg::t_CMD_SAMPLE);
            else
                send_op(3'($urandom_range(CMD_SPARE_7, CMD_SPARE_5)));
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < swvm_pkg::TABLE_SIZE / 64; k++)
            send(swvm_pkg::t_CMD_SINE, 4'($urandom), 8'($urandom), 13'(k * 64),
                 (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : 16'($urandom),
                 1'($urandom), 13'($urandom), 16'($urandom), 9'($urandom));

        // Directed part: empty voices, extremes of steps, lengths and delays.
        set_voices(5'd0);
        send_op(swvm_pkg::t_CMD_SAMPLE);
        set_voices(5'd16);
        send(swvm_pkg::t_CMD_ENTRY, 4'd0, 8'd0, '0, '0, 1'b1, 13'h1FC0, 16'd0, '0);
        send(swvm_pkg::t_CMD_ENTRY, 4'd0, 8'd1, '1, '1, 1'b0, 13'd0, 16'hFFFF, '1);
        entry_done[0][0] = 1'b1;
        entry_done[0][1] = 1'b1;
        send(swvm_pkg::t_CMD_LENGTH, 4'd0, '0, '0, '0, '0, '0, 16'd0, 9'd2);
        load_track(4'd15, 9'h1FF, 16'd0);
        load_track(4'd1, 9'd7, 16'd1);
        load_track(4'd2, 9'd0, 16'hFFFF);
        load_track(4'd3, 9'd1, 16'd0);
        send_op(CMD_SPARE_5);
        send_op(CMD_SPARE_6);
        send_op(CMD_SPARE_7);
        repeat (18) send_op(swvm_pkg::t_CMD_TICK);
        repeat (4) send_op(swvm_pkg::t_CMD_SAMPLE);
        set_voices(5'd31);
        repeat (3) send_op(swvm_pkg::t_CMD_SAMPLE);

        random_items(60);
        hold_req = 1'b1;
        repeat (30) send_op(swvm_pkg::t_CMD_SAMPLE);
        hold_req = 1'b0;
        random_items(50);
        set_voices(5'd1);
        random_items(20);
        set_voices(5'd17);

        send_idle = 62;
        recv_idle = 27;
        random_items(60);
        drain();
        random_items(50);
        set_voices(5'($urandom_range(15, 2)));
        random_items(20);
        set_voices(5'd16);

        send_idle = 0;
        recv_idle = 0;
        random_items(100);

        drain();
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
design/swvm_pkg.sv
design/swvm_cmd_ram.sv
design/sequenced_wavetable_voice_mixer.sv
tb/swvm_mix_checker.sv
tb/sequenced_wavetable_voice_mixer_tb.sv
